// File: rtl/ioir_pkg.sv
package ioir_pkg;

    localparam int NUM_PINS_DEF = 24;
    localparam int PIN_W        = 5;
    localparam int S_TDATA_W    = 56;
    localparam int M_TDATA_W    = 56;

    // request codes; 5 to 7 are unused and answered with an empty result
    localparam logic [2:0] REQ_RAISE = 3'd0;
    localparam logic [2:0] REQ_LOWER = 3'd1;
    localparam logic [2:0] REQ_EOI   = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    // incoming request, highest field first
    typedef struct packed {
        logic [31:0] write_data;
        logic [5:0]  dword_index;
        logic [7:0]  eoi_vector;
        logic [4:0]  pin;
        logic [2:0]  req_type;
    } t_request;

    // stored part of a redirection entry; reserved and delivery status bits are always zero
    typedef struct packed {
        logic [7:0] dest;
        logic       mask;
        logic       trig;
        logic       rirr;
        logic       pol;
        logic       dm;
        logic [2:0] mode;
        logic [7:0] vec;
    } t_entry;

    localparam t_entry ENTRY_RST = '{dest: 8'h00, mask: 1'b1, trig: 1'b0, rirr: 1'b0,
                                     pol: 1'b0, dm: 1'b0, mode: 3'd0, vec: 8'h00};

    // result item, highest field first (tlast travels separately)
    typedef struct packed {
        logic [31:0] read_data;
        logic        level_trig;
        logic [7:0]  destination;
        logic        dest_mode;
        logic [2:0]  delivery_mode;
        logic [7:0]  vector;
        logic        deliver;
    } t_result;

    function automatic t_result make_result(logic dlv, t_entry e);
        t_result r;
        r = '0;
        if (dlv) begin
            r.deliver       = 1'b1;
            r.vector        = e.vec;
            r.delivery_mode = e.mode;
            r.dest_mode     = e.dm;
            r.destination   = e.dest;
            r.level_trig    = e.trig;
        end
        return r;
    endfunction

    // one 32-bit half of the 64-bit datasheet view of an entry
    function automatic logic [31:0] entry_dword(t_entry e, logic hi);
        logic [31:0] d;
        if (hi) begin
            d = {e.dest, 24'h000000};
        end else begin
            d = {15'h0000, e.mask, e.trig, e.rirr, e.pol, 1'b0, e.dm, e.mode, e.vec};
        end
        return d;
    endfunction

endpackage

// File: rtl/io_interrupt_redirection.sv
// I/O interrupt redirection table.
// Slave stream carries one request per beat: raise pin, lower pin, end of
// interrupt (EOI), write entry dword, read entry dword. Master stream returns
// result beats; tlast marks the final result of a request. Only EOI can
// return more than one result: one per entry whose remote-IRR it cleared, or
// one empty result if it cleared none. A request is taken only while the
// sequencer is idle. Raise, lower, write, read and unused codes answer from
// the execute state via the output register. EOI walks the table through the
// entry RAM, one entry per cycle while no match waits on a stalled output,
// then a final state; its results are held back one step so the last is flagged.
// Reset clears pin levels, pending bits and the per-entry valid bits, so every
// entry reads as masked with all other fields zero; no clearing pass is needed.
// When the receiver stalls, the result sits in the output register and the
// sequencer waits before committing the next result; no result is dropped.
// A new request may be taken while the last result still waits.
module io_interrupt_redirection #(
    parameter int NUM_PINS = ioir_pkg::NUM_PINS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // req_type[2:0], pin[7:3], eoi_vector[15:8], dword_index[21:16],
    // write_data[53:22], zero fill [55:54]
    input  logic [ioir_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // deliver[0], vector[8:1], delivery_mode[11:9], dest_mode[12],
    // destination[20:13], level_trig[21], read_data[53:22], zero fill [55:54]
    output logic [ioir_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);
    import ioir_pkg::*;

    localparam int IW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
    localparam logic [PIN_W-1:0] LAST_IDX = PIN_W'(NUM_PINS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_LAST = 3'b100
    } t_state;

    t_state                r_state, n_state;
    t_request              r_req;
    t_request              in_req;
    logic [PIN_W-1:0]      r_idx, n_idx;
    logic [NUM_PINS-1:0]   r_lvl, n_lvl;
    logic [NUM_PINS-1:0]   r_pend, n_pend;
    logic [NUM_PINS-1:0]   r_valid;

    t_entry                r_mem [NUM_PINS];
    t_entry                r_rdata;
    logic                  r_rvalid;
    logic                  mem_we;
    t_entry                mem_wdata;

    logic                  r_ovalid;
    t_result               r_out;
    logic                  r_olast;
    logic                  load;
    t_result               load_res;
    logic                  load_last;

    logic                  r_hold_v, n_hold_v;
    t_result               r_hold, n_hold;

    t_entry                e, x;
    logic [IW-1:0]         ai;
    logic                  idx_ok;
    logic                  out_free;
    logic                  accept;
    logic                  fire;
    logic                  dlv;
    logic                  match;

    assign in_req        = t_request'(s_axis_tdata[$bits(t_request)-1:0]);
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {(M_TDATA_W - $bits(t_result))'(0), r_out};
    assign m_axis_tlast  = r_olast;

    // never-written entries read back as the reset entry
    assign e        = r_rvalid ? r_rdata : ENTRY_RST;
    assign ai       = r_idx[IW-1:0];
    assign idx_ok   = (int'(r_idx) < NUM_PINS);
    assign out_free = !r_ovalid || m_axis_tready;
    assign match    = (e.vec == r_req.eoi_vector) && e.rirr;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_lvl     = r_lvl;
        n_pend    = r_pend;
        n_hold_v  = r_hold_v;
        n_hold    = r_hold;
        mem_we    = 1'b0;
        mem_wdata = e;
        load      = 1'b0;
        load_res  = '0;
        load_last = 1'b0;
        x         = e;
        fire      = 1'b0;
        dlv       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                    case (in_req.req_type) inside
                        REQ_RAISE, REQ_LOWER: n_idx = in_req.pin;
                        REQ_EOI:              n_idx = '0;
                        default:              n_idx = in_req.dword_index[5:1];
                    endcase
                end
            end

            S_EXEC: begin
                if (r_req.req_type == REQ_EOI) begin
                    // a match must first push the held result, if any
                    if (!match || !r_hold_v || out_free) begin
                        if (match) begin
                            x.rirr = 1'b0;
                            fire   = r_pend[ai] && !x.mask;
                            if (fire && !x.trig) begin
                                n_pend[ai] = 1'b0;
                            end
                            if (fire && x.trig) begin
                                x.rirr = 1'b1;
                            end
                            mem_we    = 1'b1;
                            mem_wdata = x;
                            if (r_hold_v) begin
                                load     = 1'b1;
                                load_res = r_hold;
                            end
                            n_hold_v = 1'b1;
                            n_hold   = make_result(fire, e);
                        end
                        if (r_idx == LAST_IDX) begin
                            n_state = S_LAST;
                        end else begin
                            n_idx = r_idx + PIN_W'(1);
                        end
                    end
                end else if (out_free) begin
                    load      = 1'b1;
                    load_last = 1'b1;
                    n_state   = S_IDLE;
                    case (r_req.req_type)
                        REQ_RAISE: begin
                            if (idx_ok && !r_lvl[ai]) begin
                                n_lvl[ai] = 1'b1;
                                // masked edge-triggered pin drops the edge
                                if (!(e.mask && !e.trig)) begin
                                    fire = !e.mask;
                                    n_pend[ai] = !(fire && !e.trig);
                                    if (fire && e.trig) begin
                                        x.rirr    = 1'b1;
                                        mem_we    = 1'b1;
                                        mem_wdata = x;
                                    end
                                    dlv = fire && !(e.trig && e.rirr);
                                end
                            end
                            load_res = make_result(dlv, e);
                        end
                        REQ_LOWER: begin
                            if (idx_ok && r_lvl[ai]) begin
                                n_lvl[ai] = 1'b0;
                                if (!e.trig) begin
                                    n_pend[ai] = 1'b0;
                                end
                            end
                        end
                        REQ_WRITE: begin
                            if (idx_ok) begin
                                if (r_req.dword_index[0]) begin
                                    x.dest = r_req.write_data[31:24];
                                end else begin
                                    x.vec  = r_req.write_data[7:0];
                                    x.mode = r_req.write_data[10:8];
                                    x.dm   = r_req.write_data[11];
                                    x.pol  = r_req.write_data[13];
                                    x.trig = r_req.write_data[15];
                                    x.mask = r_req.write_data[16];
                                end
                                fire = r_pend[ai] && !x.mask;
                                dlv  = fire && !(x.trig && x.rirr);
                                if (fire && !x.trig) begin
                                    n_pend[ai] = 1'b0;
                                end
                                load_res = make_result(dlv, x);
                                if (fire && x.trig) begin
                                    x.rirr = 1'b1;
                                end
                                mem_we    = 1'b1;
                                mem_wdata = x;
                            end
                        end
                        REQ_READ: begin
                            if (idx_ok) begin
                                load_res.read_data = entry_dword(e, r_req.dword_index[0]);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_LAST: begin
                if (out_free) begin
                    load      = 1'b1;
                    load_last = 1'b1;
                    load_res  = r_hold_v ? r_hold : '0;
                    n_hold_v  = 1'b0;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lvl    <= '0;
            r_pend   <= '0;
            r_valid  <= '0;
            r_ovalid <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_lvl    <= n_lvl;
            r_pend   <= n_pend;
            r_hold_v <= n_hold_v;
            if (mem_we) begin
                r_valid[ai] <= 1'b1;
            end
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload and entry RAM
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_hold   <= n_hold;
        r_rdata  <= r_mem[n_idx[IW-1:0]];
        r_rvalid <= r_valid[n_idx[IW-1:0]];
        if (mem_we) begin
            r_mem[ai] <= mem_wdata;
        end
        if (accept) begin
            r_req <= in_req;
        end
        if (load) begin
            r_out   <= load_res;
            r_olast <= load_last;
        end
    end

endmodule
